@@ rtl/ece_pkg.sv @@
package ece_pkg;

	// Curve codes as written to the curve_select register
	typedef enum logic [3:0] {
		CURVE_LINEAR       = 4'd0,
		CURVE_SINE_IN      = 4'd1,
		CURVE_SINE_OUT     = 4'd2,
		CURVE_SINE_INOUT   = 4'd3,
		CURVE_QUAD_IN      = 4'd4,
		CURVE_QUAD_OUT     = 4'd5,
		CURVE_QUAD_INOUT   = 4'd6,
		CURVE_CUBIC_IN     = 4'd7,
		CURVE_CUBIC_OUT    = 4'd8,
		CURVE_CUBIC_INOUT  = 4'd9,
		CURVE_QUART_IN     = 4'd10,
		CURVE_QUART_OUT    = 4'd11,
		CURVE_QUART_INOUT  = 4'd12
	} curve_t;

	localparam int CURVE_W = 4;

	// Number of register stages from input to output
	localparam int PIPE_DEPTH = 5;

	// pi/2 in Q30, used to build the quarter-wave sine table
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

endpackage

@@ rtl/easing_curve_evaluator_top.sv @@
// Easing curve evaluator.
// Input stream (s_axis_*): one progress word per transfer, unsigned fixed point with
// FRACTION_BITS fraction bits; values above 1.0 are treated as 1.0.
// Output stream (m_axis_*): one eased value per input word, same format, 0 to 1.0.
// The curve comes from the curve_select register (cfg_wr_en / cfg_wr_data):
// 0 linear, 1-3 sine in/out/in-out, 4-6 quad, 7-9 cubic, 10-12 quartic;
// codes 13-15 act as linear. Write it only while no word is in flight.
// A word accepted on s_axis passes through the five register stages in order and
// then leaves on m_axis. A new word can enter
// every cycle while the output is not stalled; throughput is then one word per clock in the five-stage pipeline
// (power chain of three multipliers, sine table read and interpolation multiply).
// Each stage holds its word when the stage after it is full and cannot move, so a stall on
// m_axis_tready fills bubbles first and then pushes back to s_axis_tready; no
// word is dropped or repeated. Up to five words are held in flight.
// Reset (arst_n low) empties the pipeline and sets curve_select to linear.
// The sine table is a constant built at elaboration from FRACTION_BITS and
// SINE_TABLE_ENTRIES.
module easing_curve_evaluator_top
	import ece_pkg::*;
#(
	parameter int FRACTION_BITS      = 16,
	parameter int SINE_TABLE_ENTRIES = 256
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_wr_en,
	input  logic [CURVE_W-1:0]                       cfg_wr_data,   // curve_select
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  logic [((FRACTION_BITS+8)/8)*8-1:0]       s_axis_tdata,  // [FB:0] progress
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	output logic [((FRACTION_BITS+8)/8)*8-1:0]       m_axis_tdata   // [FB:0] eased_value
);

	localparam int FB    = FRACTION_BITS;
	localparam int VW    = FB + 1;
	localparam int DW    = ((FB + 8) / 8) * 8;
	localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
	localparam int PW    = VW + IDX_W;

	localparam logic [FB:0]      ONE      = {1'b1, {FB{1'b0}}};
	localparam logic [FB:0]      HALF_ONE = ONE >> 1;
	localparam logic [IDX_W-1:0] TAB_LAST = IDX_W'(SINE_TABLE_ENTRIES);

	typedef logic [SINE_TABLE_ENTRIES:0][FB:0] sine_tab_t;

	// Quarter-wave sine table: Taylor series through x^15 in Q30, rounded,
	// endpoints pinned and forced monotonic.
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		longint unsigned a, x2, term, sum, v, one_l;
		int i;
		one_l = 64'd1 << FB;
		tab = '0;
		for (i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
			a = (longint'(i) * HALF_PI_Q30 + SINE_TABLE_ENTRIES / 2) / SINE_TABLE_ENTRIES;
			x2 = (a * a) >> 30;
			term = a;
			sum = a;
			term = ((term * x2) >> 30) / 6;
			sum = (sum >= term) ? sum - term : 64'd0;
			term = ((term * x2) >> 30) / 20;
			sum = sum + term;
			term = ((term * x2) >> 30) / 42;
			sum = (sum >= term) ? sum - term : 64'd0;
			term = ((term * x2) >> 30) / 72;
			sum = sum + term;
			term = ((term * x2) >> 30) / 110;
			sum = (sum >= term) ? sum - term : 64'd0;
			term = ((term * x2) >> 30) / 156;
			sum = sum + term;
			term = ((term * x2) >> 30) / 210;
			sum = (sum >= term) ? sum - term : 64'd0;
			v = (sum + (64'd1 << (29 - FB))) >> (30 - FB);
			if (v > one_l) v = one_l;
			if (i == 0) v = 64'd0;
			if (i == SINE_TABLE_ENTRIES) v = one_l;
			if (i > 0 && v < longint'(tab[i-1])) v = longint'(tab[i-1]);
			tab[i] = v[FB:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	// Rounded fixed-point product; both operands are at most 1.0
	function automatic logic [FB:0] fx_mul(input logic [FB:0] a, input logic [FB:0] b);
		logic [2*FB+1:0] p;
		p = (2*FB+2)'(a) * (2*FB+2)'(b) + (2*FB+2)'(HALF_ONE);
		return p[2*FB:FB];
	endfunction

	// Halve with round half up; input is at most 2.0
	function automatic logic [FB:0] fx_half(input logic [FB+1:0] v);
		logic [FB+2:0] t;
		t = (FB+3)'(v) + (FB+3)'(1);
		return t[FB+1:1];
	endfunction

	// Configuration register
	logic [CURVE_W-1:0] curve_select_q;
	curve_t             sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_select_q <= CURVE_W'(CURVE_LINEAR);
		end else if (cfg_wr_en) begin
			curve_select_q <= cfg_wr_data;
		end
	end

	assign sel = curve_t'(curve_select_q);

	// Stage handshake: a stage loads when it is empty or the next one moves
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !v_s5 || m_axis_tready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 1: clamp, pick power base and sine argument
	logic [FB:0]   in_x, in_u, base_c, sarg_c;
	logic [FB+1:0] in_x2, in_u2;
	logic          lower_c, upper_c;

	always_comb begin
		in_x    = (s_axis_tdata[FB:0] > ONE) ? ONE : s_axis_tdata[FB:0];
		in_u    = ONE - in_x;
		in_x2   = {in_x, 1'b0};
		in_u2   = {in_u, 1'b0};
		lower_c = in_x < HALF_ONE;
		upper_c = in_x > HALF_ONE;

		unique case (sel)
			CURVE_QUAD_OUT, CURVE_CUBIC_OUT, CURVE_QUART_OUT: begin
				base_c = in_u;
			end
			CURVE_QUAD_INOUT, CURVE_CUBIC_INOUT, CURVE_QUART_INOUT: begin
				base_c = lower_c ? in_x2[FB:0] : in_u2[FB:0];
			end
			default: begin
				base_c = in_x;
			end
		endcase

		unique case (sel)
			CURVE_SINE_IN: begin
				sarg_c = in_u;
			end
			CURVE_SINE_INOUT: begin
				sarg_c = upper_c ? VW'(in_x2 - {1'b0, ONE}) : VW'({1'b0, ONE} - in_x2);
			end
			default: begin
				sarg_c = in_x;
			end
		endcase
	end

	logic [FB:0] x_s1, base_s1, sarg_s1;
	logic        lower_s1, upper_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			x_s1     <= in_x;
			base_s1  <= base_c;
			sarg_s1  <= sarg_c;
			lower_s1 <= lower_c;
			upper_s1 <= upper_c;
		end
	end

	// Stage 2: square, and table position of the sine argument
	logic [PW-1:0] pos;
	assign pos = PW'(sarg_s1) * PW'(SINE_TABLE_ENTRIES);

	logic [FB:0]      x_s2, base_s2, p2_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [FB-1:0]    frac_s2;
	logic             lower_s2, upper_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			x_s2     <= x_s1;
			base_s2  <= base_s1;
			p2_s2    <= fx_mul(base_s1, base_s1);
			idx_s2   <= pos[FB+IDX_W-1:FB];
			frac_s2  <= pos[FB-1:0];
			lower_s2 <= lower_s1;
			upper_s2 <= upper_s1;
		end
	end

	// Stage 3: cube, and read both table neighbors
	logic [IDX_W-1:0] lo_idx, hi_idx;

	always_comb begin
		if (idx_s2 >= TAB_LAST) begin
			lo_idx = TAB_LAST;
			hi_idx = TAB_LAST;
		end else begin
			lo_idx = idx_s2;
			hi_idx = idx_s2 + IDX_W'(1);
		end
	end

	logic [FB:0]   x_s3, base_s3, p2_s3, p3_s3, lo_s3, hi_s3;
	logic [FB-1:0] frac_s3;
	logic          lower_s3, upper_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			x_s3     <= x_s2;
			base_s3  <= base_s2;
			p2_s3    <= p2_s2;
			p3_s3    <= fx_mul(p2_s2, base_s2);
			lo_s3    <= SINE_TAB[lo_idx];
			hi_s3    <= SINE_TAB[hi_idx];
			frac_s3  <= frac_s2;
			lower_s3 <= lower_s2;
			upper_s3 <= upper_s2;
		end
	end

	// Stage 4: fourth power, and linear interpolation between table entries
	logic [FB:0]   diff;
	logic [2*FB:0] interp;

	assign diff   = hi_s3 - lo_s3;
	assign interp = (2*FB+1)'(diff) * (2*FB+1)'(frac_s3) + (2*FB+1)'(HALF_ONE);

	logic [FB:0] x_s4, p2_s4, p3_s4, p4_s4, sine_s4;
	logic        lower_s4, upper_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			x_s4     <= x_s3;
			p2_s4    <= p2_s3;
			p3_s4    <= p3_s3;
			p4_s4    <= fx_mul(p3_s3, base_s3);
			sine_s4  <= lo_s3 + interp[2*FB:FB];
			lower_s4 <= lower_s3;
			upper_s4 <= upper_s3;
		end
	end

	// Stage 5: shape the curve from the chosen power or sine value
	logic [FB:0] pn, half_pn, result;

	always_comb begin
		unique case (sel)
			CURVE_CUBIC_IN, CURVE_CUBIC_OUT, CURVE_CUBIC_INOUT: pn = p3_s4;
			CURVE_QUART_IN, CURVE_QUART_OUT, CURVE_QUART_INOUT: pn = p4_s4;
			default:                                            pn = p2_s4;
		endcase
		half_pn = fx_half((FB+2)'(pn));

		unique case (sel)
			CURVE_SINE_IN:  result = ONE - sine_s4;
			CURVE_SINE_OUT: result = sine_s4;
			CURVE_SINE_INOUT: begin
				result = upper_s4 ? fx_half({1'b0, ONE} + {1'b0, sine_s4})
				                  : fx_half((FB+2)'(ONE - sine_s4));
			end
			CURVE_QUAD_IN, CURVE_CUBIC_IN, CURVE_QUART_IN: begin
				result = pn;
			end
			CURVE_QUAD_OUT, CURVE_CUBIC_OUT, CURVE_QUART_OUT: begin
				result = ONE - pn;
			end
			CURVE_QUAD_INOUT, CURVE_CUBIC_INOUT, CURVE_QUART_INOUT: begin
				result = lower_s4 ? half_pn : ONE - half_pn;
			end
			default: result = x_s4;
		endcase
	end

	logic [FB:0] out_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			out_s5 <= result;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = DW'(out_s5);

endmodule

@@ rtl/ece_checker.sv @@
module ece_checker
	import ece_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [((FRACTION_BITS+8)/8)*8-1:0]   m_axis_tdata
);

	localparam int DW  = ((FRACTION_BITS + 8) / 8) * 8;
	localparam int CW  = $clog2(PIPE_DEPTH + 1);
	localparam logic [DW-1:0] ONE_D = DW'(1) << FRACTION_BITS;

	// Words accepted but not yet delivered
	logic [CW-1:0] inflight_q;
	logic          in_acc, out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + CW'(1);
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - CW'(1);
		end
	end

	// Eased value never exceeds 1.0, padding included
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata <= ONE_D)
		else $error("eased value above 1.0");

	// Stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed under stall");

	// Pipeline never holds more words than it has stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CW'(PIPE_DEPTH))
		else $error("more words in flight than pipeline stages");

	// Full pipeline with a stalled output pushes back on the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == CW'(PIPE_DEPTH) && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while pipeline full and stalled");

	// An empty pipeline shows no output word
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == '0 |-> !m_axis_tvalid)
		else $error("output valid with no word in flight");

endmodule

bind easing_curve_evaluator_top ece_checker #(
	.FRACTION_BITS(FRACTION_BITS)
) u_ece_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
